>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; expect clk and rst_n in the including scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TQH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TQH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tqh_pkg.sv
// ----------------------------------------------------------------------------
// tqh_pkg
// Shared types and constants of the topmost quad hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package tqh_pkg;

    localparam int DEPTH_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int EDGE_LAT = 3;
    localparam int DRAIN_W  = $clog2(EDGE_LAT + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_ROTATE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic               valid;
        logic               contained;
        logic [DEPTH_W-1:0] depth;
    } edge_res_t;

endpackage

`default_nettype wire

>>> rtl/topmost_quad_hit_test.sv
// ----------------------------------------------------------------------------
// topmost_quad_hit_test
// Hit test of a point against a table of four-corner outlines, newest first.
// ----------------------------------------------------------------------------
// Input words arrive on s_*; s_tuser carries the kind (clear, append, query),
// s_tdata the depth tag, the four corners and the query point. Every input
// word yields exactly one result word on m_*: status and hit in m_tuser,
// the depth tag of the topmost containing outline in m_tdata.
// Outlines sit in a chain of MAX_OUTLINES cells, newest in cell 0. An append
// pushes the chain down by one; a clear resets the fill count.
// A query rotates the whole ring once, feeding cell 0
// to a three-stage edge-sign unit; the ring is back in order at the end.
// Clear and append go from idle to emit; a query walks the ring, then drains
// the edge unit, then emits. Emit loads the output register and returns to
// idle, so a new word is taken only once the last result has left emit,
// which waits while the output register is full and not taken.
// One word is in work at a time; s_tready is high only while idle.
// Reset empties the table and the output register; no clearing pass.
// A stalled receiver holds the output word; the next input word is taken and
// processed meanwhile, and its result waits until the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module topmost_quad_hit_test #(
    parameter int MAX_OUTLINES = 64,
    parameter int COORD_WIDTH  = 24,
    localparam int TDATA_W = ((tqh_pkg::DEPTH_W + 10 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // outline_depth, corner0_x, corner0_y .. corner3_x, corner3_y, point_x, point_y
    input  wire logic [TDATA_W-1:0]            s_tdata,
    // kind
    input  wire logic [tqh_pkg::KIND_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit_depth
    output logic [tqh_pkg::DEPTH_W-1:0]        m_tdata,
    // status, hit
    output logic [tqh_pkg::STATUS_W:0]         m_tuser
);
    import tqh_pkg::*;

`include "assert_macros.svh"

    localparam int W  = COORD_WIDTH;
    localparam int CW = $clog2(MAX_OUTLINES + 1);
    localparam int OW = DEPTH_W + 8 * W;

    logic [OW-1:0]         cell_q [MAX_OUTLINES];
    cell_op_t              cell_op;

    state_t                state_reg,  state_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [CW-1:0]         step_reg,   step_next;
    logic [DRAIN_W-1:0]    drain_reg,  drain_next;
    logic                  found_reg,  found_next;
    logic [DEPTH_W-1:0]    depth_reg,  depth_next;
    status_t               status_reg, status_next;
    logic signed [W-1:0]   px_reg,     px_next;
    logic signed [W-1:0]   py_reg,     py_next;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic                  m_hit_reg;
    logic [DEPTH_W-1:0]    m_depth_reg;
    logic                  m_load;

    logic                  ev_valid;
    edge_res_t             ev_res;

    generate
        for (genvar g = 0; g < MAX_OUTLINES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                tqh_cell #(.WORD_W(OW)) u_cell (
                    .clk     (clk),
                    .op      (cell_op),
                    .push_in (s_tdata[OW-1:0]),
                    .rot_in  (cell_q[(g + 1) % MAX_OUTLINES]),
                    .q       (cell_q[g])
                );
            end
            else
            begin : g_body
                tqh_cell #(.WORD_W(OW)) u_cell (
                    .clk     (clk),
                    .op      (cell_op),
                    .push_in (cell_q[g-1]),
                    .rot_in  (cell_q[(g + 1) % MAX_OUTLINES]),
                    .q       (cell_q[g])
                );
            end
        end
    endgenerate

    tqh_edge_unit #(.COORD_WIDTH(W)) u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ev_valid),
        .outline  (cell_q[0]),
        .point_x  (px_reg),
        .point_y  (py_reg),
        .res      (ev_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        drain_reg  <= drain_next;
        found_reg  <= found_next;
        depth_reg  <= depth_next;
        status_reg <= status_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        drain_next  = drain_reg;
        found_next  = found_reg;
        depth_next  = depth_reg;
        status_next = status_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        cell_op     = CELL_HOLD;
        ev_valid    = 1'b0;
        s_tready    = 1'b0;
        m_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    found_next  = 1'b0;
                    depth_next  = '0;
                    status_next = STATUS_DONE;
                    state_next  = ST_EMIT;
                    case (s_tuser)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (count_reg < CW'(MAX_OUTLINES))
                            begin
                                cell_op    = CELL_PUSH;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        KIND_QUERY:
                        begin
                            status_next = STATUS_MISS;
                            step_next   = '0;
                            px_next     = s_tdata[OW +: W];
                            py_next     = s_tdata[OW + W +: W];
                            state_next  = ST_WALK;
                        end
                        default:
                        begin
                            status_next = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cell_op   = CELL_ROTATE;
                ev_valid  = step_reg < count_reg;
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(MAX_OUTLINES - 1))
                begin
                    drain_next = DRAIN_W'(EDGE_LAT);
                    state_next = ST_DRAIN;
                end
                if (ev_res.valid && ev_res.contained && !found_reg)
                begin
                    found_next  = 1'b1;
                    depth_next  = ev_res.depth;
                    status_next = STATUS_DONE;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(1))
                begin
                    state_next = ST_EMIT;
                end
                if (ev_res.valid && ev_res.contained && !found_reg)
                begin
                    found_next  = 1'b1;
                    depth_next  = ev_res.depth;
                    status_next = STATUS_DONE;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_status_reg <= status_reg;
            m_hit_reg    <= found_reg;
            m_depth_reg  <= depth_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_depth_reg;
    assign m_tuser  = {m_hit_reg, m_status_reg};

    `TQH_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_OUTLINES),
                    "outline count beyond table size")
    `TQH_ASSERT_NXT(a_append_grows,
                    s_tvalid && s_tready && s_tuser == KIND_APPEND && count_reg < CW'(MAX_OUTLINES),
                    count_reg == $past(count_reg) + CW'(1), "append did not grow table")
    `TQH_ASSERT_IMP(a_hit_from_unit, $rose(found_reg),
                    $past(ev_res.valid && ev_res.contained), "hit recorded without unit hit")
    `TQH_ASSERT_IMP(a_emit_source, $rose(m_valid_reg), $past(state_reg == ST_EMIT),
                    "output word raised outside emit")

endmodule

`default_nettype wire

>>> rtl/tqh_cell.sv
// ----------------------------------------------------------------------------
// tqh_cell
// One outline slot of the table chain: hold, take the neighbour above on a
// push, or the neighbour below on a rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module tqh_cell #(
    parameter int WORD_W = 208
) (
    input  wire logic               clk,
    input  wire tqh_pkg::cell_op_t  op,
    input  wire logic [WORD_W-1:0]  push_in,
    input  wire logic [WORD_W-1:0]  rot_in,
    output logic      [WORD_W-1:0]  q
);
    import tqh_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        unique case (op)
            CELL_PUSH:   word_next = push_in;
            CELL_ROTATE: word_next = rot_in;
            default:     word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

`default_nettype wire

>>> rtl/tqh_edge_unit.sv
// ----------------------------------------------------------------------------
// tqh_edge_unit
// Three-stage point-in-quad test: edge and point differences, cross
// products, sign compare and combine.
// ----------------------------------------------------------------------------
`default_nettype none

module tqh_edge_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         in_valid,
    input  wire logic [tqh_pkg::DEPTH_W+8*COORD_WIDTH-1:0]    outline,
    input  wire logic signed [COORD_WIDTH-1:0]                point_x,
    input  wire logic signed [COORD_WIDTH-1:0]                point_y,
    output tqh_pkg::edge_res_t                                res
);
    import tqh_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    logic signed [W-1:0]  cx [4];
    logic signed [W-1:0]  cy [4];

    logic signed [DW-1:0] ex_next [4];
    logic signed [DW-1:0] ey_next [4];
    logic signed [DW-1:0] qx_next [4];
    logic signed [DW-1:0] qy_next [4];
    logic signed [DW-1:0] ex_reg  [4];
    logic signed [DW-1:0] ey_reg  [4];
    logic signed [DW-1:0] qx_reg  [4];
    logic signed [DW-1:0] qy_reg  [4];
    logic                 v1_reg;
    logic [DEPTH_W-1:0]   d1_reg;

    logic signed [PW-1:0] a_next [4];
    logic signed [PW-1:0] b_next [4];
    logic signed [PW-1:0] a_reg  [4];
    logic signed [PW-1:0] b_reg  [4];
    logic                 v2_reg;
    logic [DEPTH_W-1:0]   d2_reg;

    logic                 above;
    logic                 below;
    edge_res_t            res_next;
    edge_res_t            res_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cx[k] = outline[DEPTH_W + 2*k*W +: W];
            cy[k] = outline[DEPTH_W + (2*k+1)*W +: W];
        end
        for (int i = 0; i < 4; i++)
        begin
            ex_next[i] = DW'(cx[(i == 3) ? 0 : i + 1]) - DW'(cx[i]);
            ey_next[i] = DW'(cy[(i == 3) ? 0 : i + 1]) - DW'(cy[i]);
            qx_next[i] = DW'(point_x) - DW'(cx[i]);
            qy_next[i] = DW'(point_y) - DW'(cy[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_next[i] = PW'(ex_reg[i]) * PW'(qy_reg[i]);
            b_next[i] = PW'(ey_reg[i]) * PW'(qx_reg[i]);
        end
    end

    always_comb
    begin
        above = 1'b0;
        below = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            above = above | (a_reg[i] > b_reg[i]);
            below = below | (a_reg[i] < b_reg[i]);
        end
        res_next.valid     = v2_reg;
        res_next.contained = !(above && below);
        res_next.depth     = d2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg         <= ex_next;
        ey_reg         <= ey_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        d1_reg         <= outline[DEPTH_W-1:0];
        a_reg          <= a_next;
        b_reg          <= b_next;
        d2_reg         <= d1_reg;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the topmost quad hit test.
// ----------------------------------------------------------------------------
// Words carry a clear, an append or a query (and the unused kind). A local
// outline table works out each result word as the input is taken, and the
// result side compares status, hit and depth with the oldest expected word.
// Directed cases cover edges, corners, degenerate and collinear outlines and
// the empty table. A fill test overruns the table. Random scenes of outlines
// follow, with queries near their corners and centres. They run under several
// idle and stall mixes and pauses in which the sender waits for every result;
// a backpressure test adds a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import tqh_pkg::*;

    localparam int     MAX_OUTLINES = 64;
    localparam int     COORD_W      = 24;
    localparam longint COORD_MAX    = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN    = -(64'sd1 <<< (COORD_W - 1));
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]             py;
        logic [COORD_W-1:0]             px;
        logic [3:0][1:0][COORD_W-1:0]   corner;
        logic [DEPTH_W-1:0]             depth;
    } quad_data_t;

    localparam int TDATA_W = $bits(quad_data_t);

    typedef struct packed {
        status_t            status;
        logic               hit;
        logic [DEPTH_W-1:0] depth;
    } hit_result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [DEPTH_W-1:0]     m_tdata;
    logic [STATUS_W:0]      m_tuser;

    longint                 outline_x [MAX_OUTLINES][4];
    longint                 outline_y [MAX_OUTLINES][4];
    logic [DEPTH_W-1:0]     outline_depth [MAX_OUTLINES];
    int                     outline_count = 0;

    hit_result_t            pending_results [$];
    hit_result_t            want;

    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     hold_cycles    = 0;
    int                     mismatch_count = 0;
    int                     words_sent     = 0;
    int                     queries_sent   = 0;
    int                     hits_seen      = 0;
    int                     drops_seen     = 0;

    topmost_quad_hit_test #(
        .MAX_OUTLINES (MAX_OUTLINES),
        .COORD_WIDTH  (COORD_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // sign of (to - from) x (point - from)
    function automatic int edge_side(input longint fx, input longint fy,
                                     input longint tx, input longint ty,
                                     input longint px, input longint py);
        longint lhs;
        longint rhs;
        lhs = (tx - fx) * (py - fy);
        rhs = (ty - fy) * (px - fx);
        if (lhs > rhs)
        begin
            return 1;
        end
        if (lhs < rhs)
        begin
            return -1;
        end
        return 0;
    endfunction

    function automatic bit outline_contains(input int slot, input longint px,
                                            input longint py);
        bit neg;
        bit pos;
        int side;
        int nxt;
        neg = 1'b0;
        pos = 1'b0;
        for (int e = 0; e < 4; e++)
        begin
            nxt  = (e + 1) % 4;
            side = edge_side(outline_x[slot][e], outline_y[slot][e],
                             outline_x[slot][nxt], outline_y[slot][nxt], px, py);
            if (side < 0)
            begin
                neg = 1'b1;
            end
            if (side > 0)
            begin
                pos = 1'b1;
            end
        end
        return !(neg && pos);
    endfunction

    function automatic hit_result_t predict_hit_test(input logic [KIND_W-1:0] kind,
                                                     input quad_data_t w);
        hit_result_t r;
        longint      px;
        longint      py;
        r.status = STATUS_DONE;
        r.hit    = 1'b0;
        r.depth  = '0;
        px = $signed(w.px);
        py = $signed(w.py);
        case (kind)
            KIND_CLEAR:
            begin
                outline_count = 0;
            end
            KIND_APPEND:
            begin
                if (outline_count >= MAX_OUTLINES)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    outline_depth[outline_count] = w.depth;
                    for (int k = 0; k < 4; k++)
                    begin
                        outline_x[outline_count][k] = $signed(w.corner[k][0]);
                        outline_y[outline_count][k] = $signed(w.corner[k][1]);
                    end
                    outline_count++;
                end
            end
            KIND_QUERY:
            begin
                r.status = STATUS_MISS;
                for (int n = outline_count - 1; n >= 0; n--)
                begin
                    if (outline_contains(n, px, py))
                    begin
                        r.status = STATUS_DONE;
                        r.hit    = 1'b1;
                        r.depth  = outline_depth[n];
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] coord_clamp(input longint v);
        if (v > COORD_MAX)
        begin
            return COORD_W'(COORD_MAX);
        end
        if (v < COORD_MIN)
        begin
            return COORD_W'(COORD_MIN);
        end
        return COORD_W'(v);
    endfunction

    function automatic longint rand_signed(input int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic quad_data_t random_word();
        logic [TDATA_W-1:0] raw;
        for (int i = 0; i < TDATA_W / 32; i++)
        begin
            raw[i * 32 +: 32] = $urandom;
        end
        return quad_data_t'(raw);
    endfunction

    function automatic quad_data_t fixed_outline(input logic [DEPTH_W-1:0] depth,
                                                 input int x0, input int y0,
                                                 input int x1, input int y1,
                                                 input int x2, input int y2,
                                                 input int x3, input int y3);
        quad_data_t w;
        w = '0;
        w.depth        = depth;
        w.corner[0][0] = COORD_W'(x0);
        w.corner[0][1] = COORD_W'(y0);
        w.corner[1][0] = COORD_W'(x1);
        w.corner[1][1] = COORD_W'(y1);
        w.corner[2][0] = COORD_W'(x2);
        w.corner[2][1] = COORD_W'(y2);
        w.corner[3][0] = COORD_W'(x3);
        w.corner[3][1] = COORD_W'(y3);
        return w;
    endfunction

    function automatic quad_data_t fixed_point(input int px, input int py);
        quad_data_t w;
        w    = '0;
        w.px = COORD_W'(px);
        w.py = COORD_W'(py);
        return w;
    endfunction

    // roughly convex quad about a random centre, either winding
    function automatic quad_data_t outline_word(input int span, input int radius);
        quad_data_t w;
        longint     cx;
        longint     cy;
        longint     xs [4];
        longint     ys [4];
        longint     tmp;
        w  = random_word();
        cx = rand_signed(span);
        cy = rand_signed(span);
        xs[0] = cx - $urandom_range(0, radius);
        ys[0] = cy - $urandom_range(0, radius);
        xs[1] = cx + $urandom_range(0, radius);
        ys[1] = cy - $urandom_range(0, radius);
        xs[2] = cx + $urandom_range(0, radius);
        ys[2] = cy + $urandom_range(0, radius);
        xs[3] = cx - $urandom_range(0, radius);
        ys[3] = cy + $urandom_range(0, radius);
        if ($urandom_range(1) == 1)
        begin
            tmp = xs[1]; xs[1] = xs[3]; xs[3] = tmp;
            tmp = ys[1]; ys[1] = ys[3]; ys[3] = tmp;
        end
        for (int k = 0; k < 4; k++)
        begin
            w.corner[k][0] = coord_clamp(xs[k]);
            w.corner[k][1] = coord_clamp(ys[k]);
        end
        return w;
    endfunction

    // mostly aim at a stored outline: a corner, its centre or near a corner
    function automatic quad_data_t query_word(input int radius);
        quad_data_t w;
        int         slot;
        int         k;
        w = random_word();
        if (outline_count > 0 && $urandom_range(9) < 8)
        begin
            slot = $urandom_range(0, outline_count - 1);
            k    = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0:
                begin
                    w.px = coord_clamp(outline_x[slot][k]);
                    w.py = coord_clamp(outline_y[slot][k]);
                end
                1:
                begin
                    w.px = coord_clamp((outline_x[slot][0] + outline_x[slot][2]) / 2);
                    w.py = coord_clamp((outline_y[slot][0] + outline_y[slot][2]) / 2);
                end
                default:
                begin
                    w.px = coord_clamp(outline_x[slot][k] + rand_signed(radius + 16));
                    w.py = coord_clamp(outline_y[slot][k] + rand_signed(radius + 16));
                end
            endcase
        end
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result word: status %0d hit %0d depth %h",
                         $time, m_tuser[STATUS_W-1:0], m_tuser[STATUS_W], m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                hits_seen  += want.hit;
                drops_seen += (want.status == STATUS_FULL);
                if (m_tuser[STATUS_W-1:0] !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tuser[STATUS_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser[STATUS_W] !== want.hit)
                begin
                    $display("%0t hit mismatch: expected %0d, got %0d",
                             $time, want.hit, m_tuser[STATUS_W]);
                    mismatch_count++;
                end
                if (m_tdata !== want.depth)
                begin
                    $display("%0t depth mismatch: expected %h, got %h",
                             $time, want.depth, m_tdata);
                    mismatch_count++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input quad_data_t word);
        hit_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predicted       = predict_hit_test(kind, word);
        pending_results = {pending_results, predicted};
        words_sent++;
        if (kind == KIND_QUERY)
        begin
            queries_sent++;
        end
    endtask

    // drop valid and hold until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic test_edge_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(KIND_QUERY, fixed_point(0, 0));
        send_word(KIND_UNUSED, random_word());
        send_word(KIND_APPEND, fixed_outline(16'hFFFF,
                  -8388608, -8388608, 8388607, -8388608,
                  8388607, 8388607, -8388608, 8388607));
        send_word(KIND_QUERY, fixed_point(8388607, 8388607));
        send_word(KIND_QUERY, fixed_point(-8388608, -8388608));
        send_word(KIND_QUERY, fixed_point(0, 0));
        send_word(KIND_APPEND, fixed_outline(16'h1234, 0, 0, 256, 0, 256, 256, 0, 256));
        send_word(KIND_QUERY, fixed_point(128, 0));
        send_word(KIND_QUERY, fixed_point(128, 128));
        send_word(KIND_APPEND, fixed_outline(16'h0000, 5, 5, 5, 5, 5, 5, 5, 5));
        send_word(KIND_QUERY, fixed_point(-1000, 7));
        send_word(KIND_CLEAR, random_word());
        send_word(KIND_QUERY, fixed_point(0, 0));
        send_word(KIND_APPEND, fixed_outline(16'h1234, 0, 0, 0, 256, 256, 256, 256, 0));
        send_word(KIND_QUERY, fixed_point(512, 128));
        send_word(KIND_QUERY, fixed_point(256, 256));
        send_word(KIND_APPEND, fixed_outline(16'h00AA,
                  0, 0, 256, 256, 512, 512, 768, 768));
        send_word(KIND_QUERY, fixed_point(384, 384));
        send_word(KIND_QUERY, fixed_point(256, 0));
        send_word(KIND_UNUSED, random_word());
        send_word(KIND_CLEAR, random_word());
        wait_drained();
    endtask

    task automatic test_table_full();
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        send_word(KIND_CLEAR, random_word());
        repeat (MAX_OUTLINES)
        begin
            send_word(KIND_APPEND, outline_word(0, 4096));
        end
        repeat (3)
        begin
            send_word(KIND_APPEND, outline_word(0, 4096));
            send_word(KIND_QUERY, query_word(4096));
        end
        send_word(KIND_CLEAR, random_word());
        send_word(KIND_APPEND, outline_word(0, 4096));
        send_word(KIND_QUERY, query_word(4096));
        wait_drained();
    endtask

    task automatic test_random_scenes(input int idle_pct, input int stall_pct,
                                      input int n_items);
        int start_count;
        int n_outlines;
        int n_queries;
        int radius;
        int span;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = words_sent;
        while (words_sent - start_count < n_items)
        begin
            if ($urandom_range(9) != 0)
            begin
                send_word(KIND_CLEAR, random_word());
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                n_outlines = $urandom_range(60, 70);
            end
            else if (pick < 4)
            begin
                n_outlines = $urandom_range(9, 40);
            end
            else
            begin
                n_outlines = $urandom_range(1, 8);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                radius = 0;
            end
            else if (pick < 15)
            begin
                radius = $urandom_range(1, 4096);
            end
            else if (pick < 18)
            begin
                radius = $urandom_range(4097, 1 << 16);
            end
            else
            begin
                radius = $urandom_range(1 << 16, 1 << 22);
            end
            span = radius * 3 + 1024;
            if (span > COORD_MAX)
            begin
                span = int'(COORD_MAX);
            end
            repeat (n_outlines)
            begin
                if ($urandom_range(19) == 0)
                begin
                    send_word(KIND_W'($urandom_range(0, 3)), random_word());
                end
                else
                begin
                    send_word(KIND_APPEND, outline_word(span, radius));
                end
            end
            n_queries = $urandom_range(2, 10);
            repeat (n_queries)
            begin
                send_word(KIND_QUERY, query_word(radius));
            end
            if ($urandom_range(7) == 0)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        send_word(KIND_CLEAR, random_word());
        repeat (12)
        begin
            send_word(KIND_APPEND, outline_word(2048, 1024));
            send_word(KIND_QUERY, query_word(1024));
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        test_edge_cases();
        test_table_full();
        test_random_scenes(0, 0, 400);
        test_random_scenes(74, 0, 400);
        test_random_scenes(0, 74, 400);
        test_random_scenes(10, 10, 400);
        test_backpressure();
        wait_drained();
        repeat (MAX_OUTLINES + 16)
        begin
            @(posedge clk);
        end
        $display("Covered %0d words, %0d of them queries with %0d hits, and %0d dropped appends,",
                 words_sent, queries_sent, hits_seen, drops_seen);
        $display("under free flow, sender gaps, receiver stalls and a long receiver hold-off.");
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/tqh_pkg.sv
rtl/tqh_cell.sv
rtl/tqh_edge_unit.sv
rtl/topmost_quad_hit_test.sv
tb/testbench.sv
